/* src/bmfa_pkg.sv */
// Shared types and constants of the bitmap first-fit block allocator.
package bmfa_pkg;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Field widths of the request and result words
  localparam int CMD_W   = 1;
  localparam int BYTES_W = 15;
  localparam int ALIGN_W = 13;
  localparam int OFFS_W  = 14;
  // Alignment mask width: largest alignment is 4096 bytes
  localparam int MASK_W  = ALIGN_W - 1;

  // Control of the bitmap ring, one step per cycle
  typedef struct packed {
    logic shift;  // rotate the ring by one block
    logic set;    // mark the block leaving the head as used
    logic clr;    // mark the block leaving the head as free
  } ring_ctl_t;

endpackage

/* src/bmfa_cell.sv */
// One bitmap cell: holds the used flag of one block and passes it on when the ring rotates.
module bmfa_cell (
  input  logic clk,
  input  logic rst_n,
  input  logic shift,
  input  logic d,
  output logic q
);

  logic used_r;

  // Every block is free after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (shift) begin
      used_r <= d;
    end
  end

  assign q = used_r;

endmodule

/* src/bmfa_ring.sv */
// Ring of bitmap cells: block at the head is examined, updated and fed back to the tail.
module bmfa_ring #(
  parameter int BLOCK_NUMBER = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bmfa_pkg::ring_ctl_t ctl,
  output logic               head
);

  import bmfa_pkg::*;

  logic [BLOCK_NUMBER-1:0] q;
  logic                    feed;

  // Head bit updated on its way round to the tail
  assign feed = (q[0] | ctl.set) & ~ctl.clr;
  assign head = q[0];

  // Cell j takes the bit of cell j+1; the last cell takes the updated head
  for (genvar j = 0; j < BLOCK_NUMBER; j++) begin : g_cell
    logic d;
    if (j == BLOCK_NUMBER - 1) begin : g_tail
      assign d = feed;
    end else begin : g_mid
      assign d = q[j+1];
    end
    bmfa_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (ctl.shift),
      .d     (d),
      .q     (q[j])
    );
  end

endmodule

/* src/bitmap_first_fit_block_allocator_core.sv */
// Top level of the bitmap first-fit block allocator: request sequencer and bitmap ring.
//
//  channel  handshake              word
//  -------  ---------------------  ----------------------------------------------------
//  in_      start && !busy         in_command, in_byte_count, in_align_bytes, in_free_offset
//  out_     out_valid (1 cycle)    out_ok, out_result_offset
//
// The bitmap is a ring of BLOCK_NUMBER cells that rotates by one block a cycle while busy.
// Allocate: one full rotation searches for the first fit, and on success a second
// rotation marks the run before the result is given. Free: one marking rotation; a
// span outside the pool is answered straight from idle and never raises busy.
// Otherwise busy is high from the accepting edge and drops as the strobe rises.
// Reset (synchronous) marks every block free; no sweep is needed.
// The result is shown for one cycle and the receiver cannot stall it.
module bitmap_first_fit_block_allocator_core #(
  parameter int BLOCK_BYTES  = 64,
  parameter int BLOCK_NUMBER = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bmfa_pkg::CMD_W-1:0]    in_command,
  input  logic [bmfa_pkg::BYTES_W-1:0]  in_byte_count,
  input  logic [bmfa_pkg::ALIGN_W-1:0]  in_align_bytes,
  input  logic [bmfa_pkg::OFFS_W-1:0]   in_free_offset,
  output logic                          out_valid,
  output logic                          out_ok,
  output logic [bmfa_pkg::OFFS_W-1:0]   out_result_offset
);

  import bmfa_pkg::*;

  // Byte arithmetic is wide enough for the pool end and for offset + count + block
  localparam int POOL  = BLOCK_NUMBER * BLOCK_BYTES;
  localparam int OFFW  = $clog2(POOL + 1);
  localparam int WW    = ((OFFW > BYTES_W + 2) ? OFFW : BYTES_W + 2) + 1;
  localparam int CNTW  = (BLOCK_NUMBER > 1) ? $clog2(BLOCK_NUMBER) : 1;

  localparam logic [WW-1:0]   BB      = WW'(BLOCK_BYTES);
  localparam logic [WW-1:0]   BB_M1   = WW'(BLOCK_BYTES - 1);
  localparam logic [WW-1:0]   POOL_W  = WW'(POOL);
  localparam logic [CNTW-1:0] LAST    = CNTW'(BLOCK_NUMBER - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MARK
  } state_t;

  state_t              state_r, state_nxt;
  logic                cmd_r, cmd_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic [WW-1:0]       off_r, off_nxt;     // byte offset just past the head block
  logic [WW-1:0]       spn_r, spn_nxt;     // run space once the head block joins it
  logic [WW-1:0]       req_r, req_nxt;     // alignment pad plus byte count of this run
  logic [WW-1:0]       algn_r, algn_nxt;   // aligned start of this run
  logic [WW-1:0]       lo_r, lo_nxt;       // marked blocks end strictly above lo
  logic [WW-1:0]       hi_r, hi_nxt;       // ... and at or below hi
  logic [BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic [MASK_W-1:0]   mask_r, mask_nxt;
  logic                found_r, found_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [OFFS_W-1:0]   out_off_r, out_off_nxt;

  ring_ctl_t           ctl;
  logic                head;

  // Request decode
  logic [BYTES_W-1:0]  req_bytes;
  logic [MASK_W-1:0]   m0, m1, m2, m3, m4;
  logic [WW-1:0]       span_end;
  logic                span_bad;

  // Scan step
  logic [MASK_W-1:0]   pad;
  logic                fit;
  logic                hit;

  // Zero-byte allocate counts as one byte
  assign req_bytes = (in_byte_count == '0) ? BYTES_W'(1) : in_byte_count;

  // Alignment mask: ones below the highest set bit of the alignment
  assign m0 = in_align_bytes[ALIGN_W-1:1];
  assign m1 = m0 | (m0 >> 1);
  assign m2 = m1 | (m1 >> 2);
  assign m3 = m2 | (m2 >> 4);
  assign m4 = m3 | (m3 >> 8);

  // Free span range check
  assign span_end = WW'(in_free_offset) + WW'(in_byte_count);
  assign span_bad = (WW'(in_free_offset) >= POOL_W) || (span_end > POOL_W);

  // Pad that aligns a run starting just past the head block
  assign pad = (~off_r[MASK_W-1:0] + MASK_W'(1)) & mask_r;
  assign fit = !head && (req_r <= spn_r);

  // Block at the head lies within the marked span
  assign hit = (off_r > lo_r) && (off_r <= hi_r);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    off_nxt       = off_r;
    spn_nxt       = spn_r;
    req_nxt       = req_r;
    algn_nxt      = algn_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    bytes_nxt     = bytes_r;
    mask_nxt      = mask_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_off_nxt   = out_off_r;
    ctl           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_command[0];
          cnt_nxt   = '0;
          off_nxt   = BB;
          spn_nxt   = BB;
          req_nxt   = WW'(req_bytes);
          algn_nxt  = '0;
          bytes_nxt = req_bytes;
          mask_nxt  = m4;
          found_nxt = 1'b0;
          lo_nxt    = WW'(in_free_offset);
          hi_nxt    = span_end + BB_M1;
          if (in_command[0] == CMD_ALLOC) begin
            state_nxt = S_SCAN;
          end else if (span_bad) begin
            out_valid_nxt = 1'b1;
            out_ok_nxt    = 1'b0;
            out_off_nxt   = '0;
          end else begin
            state_nxt = S_MARK;
          end
        end
      end

      // Search rotation: first fit wins, later blocks only rotate past
      S_SCAN: begin
        ctl.shift = 1'b1;
        cnt_nxt   = cnt_r + CNTW'(1);
        off_nxt   = off_r + BB;
        if (!found_r) begin
          if (head) begin
            spn_nxt  = BB;
            algn_nxt = off_r + WW'(pad);
            req_nxt  = WW'(pad) + WW'(bytes_r);
          end else if (fit) begin
            found_nxt = 1'b1;
            lo_nxt    = algn_r;
            hi_nxt    = off_r;
          end else begin
            spn_nxt = spn_r + BB;
          end
        end
        if (cnt_r == LAST) begin
          cnt_nxt = '0;
          off_nxt = BB;
          if (found_r || fit) begin
            state_nxt = S_MARK;
          end else begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            out_ok_nxt    = 1'b0;
            out_off_nxt   = '0;
          end
        end
      end

      // Marking rotation: set or clear blocks within the span
      S_MARK: begin
        ctl.shift = 1'b1;
        ctl.set   = hit && (cmd_r == CMD_ALLOC);
        ctl.clr   = hit && (cmd_r == CMD_FREE);
        cnt_nxt   = cnt_r + CNTW'(1);
        off_nxt   = off_r + BB;
        if (cnt_r == LAST) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_off_nxt   = (cmd_r == CMD_ALLOC) ? lo_r[OFFS_W-1:0] : '0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    off_r     <= off_nxt;
    spn_r     <= spn_nxt;
    req_r     <= req_nxt;
    algn_r    <= algn_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    bytes_r   <= bytes_nxt;
    mask_r    <= mask_nxt;
    out_ok_r  <= out_ok_nxt;
    out_off_r <= out_off_nxt;
  end

  bmfa_ring #(
    .BLOCK_NUMBER (BLOCK_NUMBER)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .head  (head)
  );

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_result_offset = out_off_r;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the bitmap first-fit block allocator core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bmfa_pkg::*;

  localparam int BLK_BYTES  = 64;
  localparam int BLK_NUM    = 256;
  localparam int STALL_MAX  = 4000;  // cycles with no word in or out
  localparam int TAIL_WAIT  = 600;   // longer than a marking allocate
  localparam int PHASE_LEN  = 390;

  // One request word and one answer word
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BYTES_W-1:0] nbytes;
    logic [ALIGN_W-1:0] align;
    logic [OFFS_W-1:0]  foffs;
  } word_t;

  typedef struct packed {
    logic              ok;
    logic [OFFS_W-1:0] offs;
  } answer_t;

  typedef struct packed {
    word_t   w;
    logic    typed;  // answer column holds the expected answer
    answer_t ans;
  } dir_row_t;

  typedef struct {
    int      idx;
    answer_t ans;
  } due_t;

  typedef struct {
    int unsigned offs;
    int unsigned len;
  } region_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    in_command = '0;
  logic [BYTES_W-1:0]  in_byte_count = '0;
  logic [ALIGN_W-1:0]  in_align_bytes = '0;
  logic [OFFS_W-1:0]   in_free_offset = '0;
  logic                out_valid;
  logic                out_ok;
  logic [OFFS_W-1:0]   out_result_offset;

  bit      blk_taken [BLK_NUM];
  due_t    answers_due [$];
  region_t live_regions [$];
  int      errors = 0;
  int      words_sent = 0;
  int      idle_pct = 0;
  int      stall_cnt = 0;
  due_t    oldest;

  // Directed words, starting from an empty pool
  dir_row_t dir_tab [26] = '{
    '{'{CMD_ALLOC, 15'd64,    13'd1,    14'd0},     1'b1, '{1'b1, 14'd0}},
    // zero bytes with zero alignment lands on the next free block
    '{'{CMD_ALLOC, 15'd0,     13'd0,    14'd0},     1'b1, '{1'b1, 14'd64}},
    '{'{CMD_ALLOC, 15'd16384, 13'd1,    14'd0},     1'b1, '{1'b0, 14'd0}},
    '{'{CMD_FREE,  15'd2,     13'd1,    14'd16383}, 1'b1, '{1'b0, 14'd0}},
    '{'{CMD_FREE,  15'd16384, 13'd1,    14'd0},     1'b1, '{1'b1, 14'd0}},
    '{'{CMD_ALLOC, 15'd16384, 13'd4096, 14'd0},     1'b1, '{1'b1, 14'd0}},
    '{'{CMD_ALLOC, 15'd1,     13'd1,    14'd0},     1'b1, '{1'b0, 14'd0}},
    // zero-byte free off a block boundary, then on one
    '{'{CMD_FREE,  15'd0,     13'd1,    14'd100},   1'b1, '{1'b1, 14'd0}},
    '{'{CMD_FREE,  15'd0,     13'd1,    14'd128},   1'b1, '{1'b1, 14'd0}},
    '{'{CMD_ALLOC, 15'd64,    13'd1,    14'd0},     1'b0, '{1'b0, 14'd0}},
    '{'{CMD_FREE,  15'd16384, 13'd1,    14'd0},     1'b1, '{1'b1, 14'd0}},
    '{'{CMD_FREE,  15'd16384, 13'd1,    14'd0},     1'b1, '{1'b1, 14'd0}},
    '{'{CMD_ALLOC, 15'd64,    13'd1,    14'd0},     1'b0, '{1'b0, 14'd0}},
    // alignment that is not a power of two
    '{'{CMD_ALLOC, 15'd100,   13'd4095, 14'd0},     1'b0, '{1'b0, 14'd0}},
    '{'{CMD_ALLOC, 15'h7fff,  13'h1fff, 14'h3fff},  1'b1, '{1'b0, 14'd0}},
    '{'{CMD_FREE,  15'h7fff,  13'h1fff, 14'h3fff},  1'b1, '{1'b0, 14'd0}},
    '{'{CMD_ALLOC, 15'd0,     13'd4096, 14'd0},     1'b0, '{1'b0, 14'd0}},
    '{'{CMD_ALLOC, 15'd200,   13'd96,   14'd0},     1'b0, '{1'b0, 14'd0}},
    '{'{CMD_FREE,  15'd64,    13'd1,    14'd16320}, 1'b1, '{1'b1, 14'd0}},
    '{'{CMD_FREE,  15'd0,     13'd1,    14'd16383}, 1'b1, '{1'b1, 14'd0}},
    '{'{CMD_ALLOC, 15'd300,   13'd2,    14'd0},     1'b0, '{1'b0, 14'd0}},
    '{'{CMD_FREE,  15'd16384, 13'd1,    14'd0},     1'b1, '{1'b1, 14'd0}},
    '{'{CMD_ALLOC, 15'd16321, 13'd1,    14'd0},     1'b1, '{1'b1, 14'd0}},
    '{'{CMD_FREE,  15'd16320, 13'd1,    14'd64},    1'b1, '{1'b1, 14'd0}},
    '{'{CMD_ALLOC, 15'd16384, 13'd1,    14'd0},     1'b1, '{1'b0, 14'd0}},
    '{'{CMD_FREE,  15'd16384, 13'd1,    14'd0},     1'b1, '{1'b1, 14'd0}}
  };

  bitmap_first_fit_block_allocator_core #(
    .BLOCK_BYTES  (BLK_BYTES),
    .BLOCK_NUMBER (BLK_NUM)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_byte_count     (in_byte_count),
    .in_align_bytes    (in_align_bytes),
    .in_free_offset    (in_free_offset),
    .out_valid         (out_valid),
    .out_ok            (out_ok),
    .out_result_offset (out_result_offset)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Answer of the allocator to one word; updates the block map
  function automatic answer_t allocator_answer(input word_t w);
    answer_t     a;
    int unsigned nb, al, need, run_start, run_len, start_off, space, adj;
    int unsigned first, last;
    a = '0;
    if (w.cmd == CMD_ALLOC) begin
      nb = (w.nbytes == 0) ? 1 : 32'(w.nbytes);
      // highest set bit is the alignment, none means byte aligned
      al = 1;
      for (int k = 0; k < ALIGN_W; k++) if (w.align[k]) al = 1 << k;
      need = (nb + BLK_BYTES - 1) / BLK_BYTES;
      run_start = 0;
      run_len = 0;
      for (int i = 0; i < BLK_NUM; i++) begin
        if (blk_taken[i]) begin
          run_len = 0;
          run_start = i + 1;
        end else begin
          run_len++;
          if (run_len >= need) begin
            start_off = run_start * BLK_BYTES;
            space = run_len * BLK_BYTES;
            adj = (0 - start_off) & (al - 1);
            if (nb <= space && adj <= space - nb) begin
              for (int b = (start_off + adj) / BLK_BYTES; b <= i; b++) blk_taken[b] = 1'b1;
              a.ok = 1'b1;
              a.offs = OFFS_W'(start_off + adj);
              return a;
            end
          end
        end
      end
    end else begin
      first = 32'(w.foffs);
      last = 32'(w.nbytes);
      last = (first + last + BLK_BYTES - 1) / BLK_BYTES;
      first = first / BLK_BYTES;
      if (first < BLK_NUM && last <= BLK_NUM) begin
        for (int b = first; b < last; b++) blk_taken[b] = 1'b0;
        a.ok = 1'b1;
      end
    end
    return a;
  endfunction

  // Mostly allocations and frees of live regions, some noise
  function automatic word_t random_word();
    word_t   w;
    region_t rg;
    int      r, sel, idx;
    w.cmd = CMD_ALLOC;
    w.foffs = OFFS_W'($urandom_range(0, 16383));
    sel = $urandom_range(0, 99);
    w.align = (sel < 75) ? ALIGN_W'(1 << $urandom_range(0, 6)) :
              (sel < 88) ? ALIGN_W'(1 << $urandom_range(7, 12)) :
                           ALIGN_W'($urandom_range(0, 8191));
    sel = $urandom_range(0, 99);
    w.nbytes = (sel < 70) ? BYTES_W'($urandom_range(1, 256)) :
               (sel < 90) ? BYTES_W'($urandom_range(257, 2048)) :
               (sel < 97) ? BYTES_W'($urandom_range(2049, 16384)) :
                            BYTES_W'($urandom_range(0, 32767));
    r = $urandom_range(0, 99);
    if (r >= 48 && live_regions.size() != 0 && r < 88) begin
      idx = $urandom_range(0, live_regions.size() - 1);
      rg = live_regions[idx];
      live_regions.delete(idx);
      w.cmd = CMD_FREE;
      w.foffs = OFFS_W'(rg.offs);
      w.nbytes = BYTES_W'(rg.len);
    end else if (r >= 88) begin
      w.cmd = CMD_FREE;
      w.nbytes = ($urandom_range(0, 1) == 0) ? BYTES_W'($urandom_range(0, 128)) :
                                                BYTES_W'($urandom_range(0, 32767));
    end
    return w;
  endfunction

  // Stop sending until every answer has come back
  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // Present one word, wait for it to be taken, record its answer
  task automatic send_word(input word_t w, input logic typed, input answer_t ans);
    int      gap;
    answer_t pred;
    due_t    d;
    gap = 0;
    if (idle_pct > 0) begin
      if ($urandom_range(0, 199) == 0) hold_until_drained();
      if ($urandom_range(0, 99) < 15) gap = $urandom_range(0, 600);
      else while ($urandom_range(0, 99) < idle_pct) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_command     <= w.cmd;
    in_byte_count  <= w.nbytes;
    in_align_bytes <= w.align;
    in_free_offset <= w.foffs;
    forever begin
      @(posedge clk);
      if (busy === 1'b0) break;
    end
    pred = allocator_answer(w);
    d.idx = words_sent;
    d.ans = typed ? ans : pred;
    answers_due.push_back(d);
    words_sent++;
    if (w.cmd == CMD_ALLOC && pred.ok) begin
      live_regions.push_back('{offs: 32'(pred.offs), len: 32'(w.nbytes)});
    end
  endtask

  // Answer checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("answer with none due: ok %0b offset %0d",
                                  out_ok, out_result_offset));
      end else begin
        oldest = answers_due.pop_front();
        if (out_ok !== oldest.ans.ok)
          report_mismatch($sformatf("word %0d: ok %0b, expected %0b",
                                    oldest.idx, out_ok, oldest.ans.ok));
        if (out_result_offset !== oldest.ans.offs)
          report_mismatch($sformatf("word %0d: offset %0d, expected %0d",
                                    oldest.idx, out_result_offset, oldest.ans.offs));
      end
    end
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Stimulus sequence
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 21;
    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].ans);

    for (int p = 0; p < 3; p++) begin
      hold_until_drained();
      idle_pct = (p == 0) ? 21 : (p == 1) ? 79 : 0;
      repeat (PHASE_LEN) send_word(random_word(), 1'b0, '0);
    end

    hold_until_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/bmfa_pkg.sv
src/bmfa_cell.sv
src/bmfa_ring.sv
src/bitmap_first_fit_block_allocator_core.sv
tb/testbench.sv
